### src/tmsa_pkg.sv
// Shared types, register codes and the bit-spread function of the Morton swizzle address block.
package tmsa_pkg;

    // Coordinate width of the pixel fields.
    localparam int unsigned COORD_BITS = 12;
    localparam int unsigned ADDR_BITS  = 32;
    localparam int unsigned STRIDE_BITS = 16;
    localparam int unsigned LOG2_BITS  = 4;
    localparam int unsigned MODE_BITS  = 2;
    localparam int unsigned MORTON_BITS = 2 * COORD_BITS;

    // APB port geometry: six 32-bit registers at byte offsets 4*i.
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_BASE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_BASE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_LOG2      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_LOG2     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_SIZE_MODE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE      = 3'd5;

    // Pixel size codes.
    localparam logic [MODE_BITS-1:0] PIX_SIZE_1B   = 2'd0;
    localparam logic [MODE_BITS-1:0] PIX_SIZE_2B   = 2'd1;
    localparam logic [MODE_BITS-1:0] PIX_SIZE_4B   = 2'd2;
    localparam logic [MODE_BITS-1:0] PIX_SIZE_RSVD = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] read_address;
        logic [ADDR_BITS-1:0] write_address;
        logic                 outside_texture;
    } addr_out_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   source_base;
        logic [ADDR_BITS-1:0]   target_base;
        logic [LOG2_BITS-1:0]   width_log2;
        logic [LOG2_BITS-1:0]   height_log2;
        logic [MODE_BITS-1:0]   pixel_size_mode;
        logic [STRIDE_BITS-1:0] row_stride;
    } cfg_t;

    // Place bit i of v at bit 2i.
    function automatic logic [MORTON_BITS-1:0] spread_bits(input logic [COORD_BITS-1:0] v);
        logic [MORTON_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

endpackage

### src/tmsa_cfg_regs.sv
// APB configuration register file of the Morton swizzle address block.
module tmsa_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmsa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tmsa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tmsa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output tmsa_pkg::cfg_t                      cfg
);

    tmsa_pkg::cfg_t                  cfg_reg;
    tmsa_pkg::cfg_t                  cfg_next;
    logic [tmsa_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[tmsa_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Decode the write into the addressed register; drop writes beyond the list.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                tmsa_pkg::REG_SOURCE_BASE:     cfg_next.source_base = pwdata;
                tmsa_pkg::REG_TARGET_BASE:     cfg_next.target_base = pwdata;
                tmsa_pkg::REG_WIDTH_LOG2:
                    cfg_next.width_log2 = pwdata[tmsa_pkg::LOG2_BITS-1:0];
                tmsa_pkg::REG_HEIGHT_LOG2:
                    cfg_next.height_log2 = pwdata[tmsa_pkg::LOG2_BITS-1:0];
                tmsa_pkg::REG_PIXEL_SIZE_MODE:
                    cfg_next.pixel_size_mode = pwdata[tmsa_pkg::MODE_BITS-1:0];
                tmsa_pkg::REG_ROW_STRIDE:
                    cfg_next.row_stride = pwdata[tmsa_pkg::STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register.
    always_comb begin
        unique case (reg_idx)
            tmsa_pkg::REG_SOURCE_BASE:     prdata = cfg_reg.source_base;
            tmsa_pkg::REG_TARGET_BASE:     prdata = cfg_reg.target_base;
            tmsa_pkg::REG_WIDTH_LOG2:      prdata = 32'(cfg_reg.width_log2);
            tmsa_pkg::REG_HEIGHT_LOG2:     prdata = 32'(cfg_reg.height_log2);
            tmsa_pkg::REG_PIXEL_SIZE_MODE: prdata = 32'(cfg_reg.pixel_size_mode);
            tmsa_pkg::REG_ROW_STRIDE:      prdata = 32'(cfg_reg.row_stride);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/tmsa_addr_calc.sv
// Combinational source and Morton destination address computation for one pixel.
module tmsa_addr_calc (
    input  tmsa_pkg::cfg_t      cfg,
    input  tmsa_pkg::pixel_in_t pix,
    output tmsa_pkg::addr_out_t res
);

    localparam int unsigned PROD_BITS = tmsa_pkg::STRIDE_BITS + tmsa_pkg::COORD_BITS;

    logic [1:0]                         size_shift;
    logic [tmsa_pkg::LOG2_BITS-1:0]     side;
    logic [tmsa_pkg::COORD_BITS-1:0]    lmask;
    logic [tmsa_pkg::COORD_BITS-1:0]    tile;
    logic [tmsa_pkg::MORTON_BITS-1:0]   morton;
    logic [tmsa_pkg::ADDR_BITS-1:0]     tile_base;
    logic [tmsa_pkg::ADDR_BITS-1:0]     elem;
    logic [PROD_BITS-1:0]               row_off;
    logic                               outside;

    // Saturate the reserved size code to four bytes.
    always_comb begin
        unique case (cfg.pixel_size_mode)
            tmsa_pkg::PIX_SIZE_1B:   size_shift = 2'd0;
            tmsa_pkg::PIX_SIZE_2B:   size_shift = 2'd1;
            tmsa_pkg::PIX_SIZE_4B:   size_shift = 2'd2;
            tmsa_pkg::PIX_SIZE_RSVD: size_shift = 2'd2;
            default:                 size_shift = 2'd2;
        endcase
    end

    // Flag coordinates with bits at or above the configured log2 size.
    assign outside = ((pix.pixel_x >> cfg.width_log2) != '0) ||
                     ((pix.pixel_y >> cfg.height_log2) != '0);

    // Tile side is the shorter edge; tiles run along the longer edge.
    assign side  = (cfg.width_log2 < cfg.height_log2) ? cfg.width_log2 : cfg.height_log2;
    assign lmask = ~({tmsa_pkg::COORD_BITS{1'b1}} << side);
    assign tile  = (cfg.width_log2 > cfg.height_log2) ? (pix.pixel_x >> side)
                                                      : (pix.pixel_y >> side);

    // Interleave local x on even bits and local y on odd bits.
    assign morton = (tmsa_pkg::spread_bits(pix.pixel_y & lmask) << 1) |
                    tmsa_pkg::spread_bits(pix.pixel_x & lmask);

    // Tile bits sit above bit 2*side and the Morton bits below, so OR is the sum.
    assign tile_base = tmsa_pkg::ADDR_BITS'(tile) << {side, 1'b0};
    assign elem      = tile_base | tmsa_pkg::ADDR_BITS'(morton);

    assign row_off = PROD_BITS'(cfg.row_stride) * PROD_BITS'(pix.pixel_y);

    always_comb begin
        res.read_address    = cfg.source_base + tmsa_pkg::ADDR_BITS'(row_off) +
                              (tmsa_pkg::ADDR_BITS'(pix.pixel_x) << size_shift);
        res.write_address   = outside ? '0 : cfg.target_base + (elem << size_shift);
        res.outside_texture = outside;
    end

endmodule

### src/texture_morton_swizzle_address.sv
// Path: an accepted item passes the input register, then the output register, to its result on m_valid.
// Throughput: one item per cycle; s_ready drops only while both registers hold stalled items.
// The single stage of address logic between the registers sets that rate.
// Reset (aresetn low, synchronous) clears all configuration registers and both valid flags.
// Top level of the Morton swizzle address block: APB config, input register, output register.
module texture_morton_swizzle_address (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tmsa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tmsa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tmsa_pkg::pixel_in_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tmsa_pkg::addr_out_t               m_data
);

    tmsa_pkg::cfg_t      cfg;
    tmsa_pkg::pixel_in_t in_data_reg;
    logic                in_valid_reg;
    tmsa_pkg::addr_out_t calc_res;
    tmsa_pkg::addr_out_t out_data_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                in_free;

    tmsa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmsa_addr_calc u_calc (
        .cfg (cfg),
        .pix (in_data_reg),
        .res (calc_res)
    );

    // Each register takes a new item when empty or when its item moves on.
    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    // Hold control flags under reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Advance payloads.
    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_data_reg <= s_data;
        end
        if (out_free && in_valid_reg) begin
            out_data_reg <= calc_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // An accepted item lands in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item not captured");

    // An item in the input register moves out when the output side is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |=> m_valid)
        else $error("item lost between stages");

    // An out-of-texture result carries a zero destination address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.outside_texture |-> m_data.write_address == '0)
        else $error("outside item with nonzero write address");

    // The input side is never blocked while the output register is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty output");

endmodule
